[rtl/wpd_pkg.sv]
// Shared types and constants for the windowed phase detector.
`timescale 1ns / 1ps
`default_nettype none

package wpd_pkg;

   // Payload widths fixed by the channel definitions
   localparam int PHASE_W    = 48;
   localparam int DEADZONE_W = 15;
   localparam int WINDOW_W   = 16;
   localparam int DELAY_W    = 16;
   localparam int ACQUIRE_W  = 32;
   localparam int TICK_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   typedef logic [PHASE_W-1:0]    phase_type;
   typedef logic [CSR_IDX_W-1:0]  csr_index_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;
   typedef logic [1:0]            det_state_type;

   // Configuration register indexes
   localparam csr_index_type REG_DEADZONE = 2'd0;
   localparam csr_index_type REG_WINDOW   = 2'd1;
   localparam csr_index_type REG_DELAY    = 2'd2;
   localparam csr_index_type REG_ACQUIRE  = 2'd3;

   // Reset values of the configuration registers
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd32768;

   // Detector state codes
   localparam det_state_type DET_DFF_LOW  = 2'd0;
   localparam det_state_type DET_DFF_HIGH = 2'd1;
   localparam det_state_type DET_SOURCE   = 2'd2;

endpackage : wpd_pkg

`default_nettype wire

[rtl/wpd_req_if.sv]
// Input channel: one tick of input and feedback phase.
`timescale 1ns / 1ps
`default_nettype none

interface wpd_req_if;
   import wpd_pkg::*;

   logic      valid;
   logic      ready;
   phase_type input_phase;
   phase_type feedback_phase;

   modport source (output valid, output input_phase, output feedback_phase, input ready);
   modport sink   (input valid, input input_phase, input feedback_phase, output ready);
endinterface : wpd_req_if

`default_nettype wire

[rtl/wpd_rsp_if.sv]
// Result channel: detector state and flags for one tick.
`timescale 1ns / 1ps
`default_nettype none

interface wpd_rsp_if;
   import wpd_pkg::*;

   logic          valid;
   logic          ready;
   det_state_type detector_state;
   logic          source_mode;
   logic          speed_up;
   logic          direction_bit;
   logic          changed;
   logic          overlap_error;

   modport source (output valid, output detector_state, output source_mode,
                   output speed_up, output direction_bit, output changed,
                   output overlap_error, input ready);
   modport sink   (input valid, input detector_state, input source_mode,
                   input speed_up, input direction_bit, input changed,
                   input overlap_error, output ready);
endinterface : wpd_rsp_if

`default_nettype wire

[rtl/wpd_csr_if.sv]
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps
`default_nettype none

interface wpd_csr_if;
   import wpd_pkg::*;

   logic          valid;
   logic          ready;
   csr_index_type index;
   csr_data_type  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface : wpd_csr_if

`default_nettype wire

[rtl/windowed_phase_detector.sv]
// Windowed phase detector top level: sampling flip-flops, delay timers, window decision.
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Payload                                            | Item accepted when
// ---------+-----+----------------------------------------------------+-------------------
// req_ch   | in  | input_phase, feedback_phase                        | valid && ready
// rsp_ch   | out | detector_state, source_mode, speed_up,             | valid && ready
//          |     | direction_bit, changed, overlap_error              |
// csr_ch   | in  | index, data                                        | valid && ready
//
// One item per cycle while results are taken: all per-tick work is one pass of compares
// and short adds between the state registers and the result register, so the result
// appears the cycle after the item is accepted. The result register frees up as it is
// taken, so a new item enters in the same cycle the old result leaves. Synchronous reset
// restores all state but the result payload; the configuration port is always ready.

module windowed_phase_detector #(
   parameter int FRAC_BITS  = 16,
   parameter int CYCLE_BITS = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   wpd_req_if.sink   req_ch,
   wpd_rsp_if.source rsp_ch,
   wpd_csr_if.sink   csr_ch
);
   import wpd_pkg::*;

   // Compare width covers both the fraction and the 16-bit registers plus carry
   localparam int CW = ((FRAC_BITS > 16) ? FRAC_BITS : 16) + 2;
   localparam logic [CW-1:0] ONE  = CW'(1) << FRAC_BITS;
   localparam logic [CW-1:0] HALF = CW'(1) << (FRAC_BITS - 1);
   localparam logic [CW-1:0] QUARTER = CW'(1) << (FRAC_BITS - 2);

   // Configuration registers
   logic [DEADZONE_W-1:0] deadzone_ff;
   logic [WINDOW_W-1:0]   window_ff;
   logic [DELAY_W-1:0]    delay_ff;
   logic [ACQUIRE_W-1:0]  acquire_ff;

   // Detector state
   logic [CYCLE_BITS-1:0] fb_seen_ff,   fb_seen_in;
   logic [CYCLE_BITS-1:0] in_seen_ff,   in_seen_in;
   logic                  smp1_ff,      smp1_in;
   logic                  smp2_ff,      smp2_in;
   logic                  on1_ff,       on1_in;
   logic                  on2_ff,       on2_in;
   logic [DELAY_W-1:0]    cnt1_ff,      cnt1_in;
   logic [DELAY_W-1:0]    cnt2_ff,      cnt2_in;
   logic                  dff_out_ff,   dff_out_in;
   logic                  dir_out_ff,   dir_out_in;
   logic                  mode_ff,      mode_in;
   logic                  dir_flag_ff,  dir_flag_in;
   det_state_type         last_state_ff;
   logic [TICK_W-1:0]     tick_ff;

   // Result register
   logic                  rsp_valid_ff;
   det_state_type         rsp_state_ff;
   logic                  rsp_mode_ff;
   logic                  rsp_speed_ff;
   logic                  rsp_dir_ff;
   logic                  rsp_changed_ff;
   logic                  rsp_err_ff;

   logic                  accept;
   logic [CW-1:0]         dz_eff;
   logic [CYCLE_BITS-1:0] fb_whole, in_whole;
   logic [63:0]           fb_shift, in_shift;
   logic                  fb_cross, in_cross;
   logic                  err1, err2;
   logic                  fb_level, in_level;
   logic [FRAC_BITS-1:0]  diff;
   logic [CW-1:0]         phase_gap;
   logic                  windowed;
   det_state_type         state_in;
   logic                  changed_in;

   // Level of a clock at the given phase; inside the deadzone toggle the previous sample
   function automatic logic sample_level(input logic [FRAC_BITS-1:0] frac,
                                         input logic [CW-1:0] dz,
                                         input logic prev);
      logic [CW-1:0] f;
      logic          res;
      f = CW'(frac);
      if (f > dz && (f + dz) < HALF)
         res = 1'b1;
      else if (f > (HALF + dz) && (f + dz) < ONE)
         res = 1'b0;
      else
         res = ~prev;
      return res;
   endfunction

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign csr_ch.ready = 1'b1;

   // Effective deadzone: above a quarter cycle it folds back from the half cycle
   always_comb begin
      dz_eff = CW'(deadzone_ff);
      if (dz_eff > QUARTER)
         dz_eff = (dz_eff < HALF) ? (HALF - dz_eff) : '0;
   end

   // Whole-cycle parts of both phases
   assign fb_shift = {{(64 - PHASE_W){1'b0}}, req_ch.feedback_phase} >> FRAC_BITS;
   assign in_shift = {{(64 - PHASE_W){1'b0}}, req_ch.input_phase} >> FRAC_BITS;
   assign fb_whole = fb_shift[CYCLE_BITS-1:0];
   assign in_whole = in_shift[CYCLE_BITS-1:0];
   assign fb_cross = fb_whole >= fb_seen_ff;
   assign in_cross = in_whole >= in_seen_ff;

   assign fb_level = sample_level(req_ch.input_phase[FRAC_BITS-1:0], dz_eff, smp1_ff);
   assign in_level = sample_level(req_ch.feedback_phase[FRAC_BITS-1:0], dz_eff, smp2_ff);

   // Feedback crossing samples the input clock; run its delay timer
   always_comb begin
      fb_seen_in = fb_seen_ff;
      smp1_in    = smp1_ff;
      on1_in     = on1_ff;
      cnt1_in    = cnt1_ff;
      dff_out_in = dff_out_ff;
      err1       = 1'b0;
      if (fb_cross) begin
         fb_seen_in = fb_seen_ff + 1'b1;
         if (on1_ff) begin
            err1 = 1'b1;
         end else begin
            smp1_in = fb_level;
            on1_in  = 1'b1;
            cnt1_in = delay_ff;
         end
      end
      if (on1_ff) begin
         if (cnt1_ff == '0) begin
            dff_out_in = smp1_ff;
            on1_in     = 1'b0;
         end else begin
            cnt1_in = cnt1_ff - 1'b1;
         end
      end
   end

   // Input crossing samples the feedback clock; run its delay timer
   always_comb begin
      in_seen_in = in_seen_ff;
      smp2_in    = smp2_ff;
      on2_in     = on2_ff;
      cnt2_in    = cnt2_ff;
      dir_out_in = dir_out_ff;
      err2       = 1'b0;
      if (in_cross) begin
         in_seen_in = in_seen_ff + 1'b1;
         if (on2_ff) begin
            err2 = 1'b1;
         end else begin
            smp2_in = in_level;
            on2_in  = 1'b1;
            cnt2_in = delay_ff;
         end
      end
      if (on2_ff) begin
         if (cnt2_ff == '0) begin
            dir_out_in = smp2_ff;
            on2_in     = 1'b0;
         end else begin
            cnt2_in = cnt2_ff - 1'b1;
         end
      end
   end

   // Phase error folded to the nearer side, then the window decision
   assign diff      = req_ch.feedback_phase[FRAC_BITS-1:0] - req_ch.input_phase[FRAC_BITS-1:0];
   assign phase_gap = (CW'(diff) > HALF) ? (ONE - CW'(diff)) : CW'(diff);
   assign windowed  = (phase_gap >= CW'(window_ff)) && (tick_ff > acquire_ff);

   always_comb begin
      dir_flag_in = dir_flag_ff;
      if (windowed) begin
         mode_in     = 1'b1;
         dir_flag_in = ~dir_out_in;
         state_in    = DET_SOURCE;
      end else begin
         mode_in  = 1'b0;
         state_in = dff_out_in ? DET_DFF_HIGH : DET_DFF_LOW;
      end
      changed_in = (state_in != last_state_ff) || (mode_in != mode_ff);
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_ff <= '0;
         window_ff   <= WINDOW_RESET;
         delay_ff    <= '0;
         acquire_ff  <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_DEADZONE: deadzone_ff <= csr_ch.data[DEADZONE_W-1:0];
            REG_WINDOW:   window_ff   <= csr_ch.data[WINDOW_W-1:0];
            REG_DELAY:    delay_ff    <= csr_ch.data[DELAY_W-1:0];
            REG_ACQUIRE:  acquire_ff  <= csr_ch.data[ACQUIRE_W-1:0];
            default:      ;
         endcase
      end
   end

   // Advance detector state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         fb_seen_ff    <= '0;
         in_seen_ff    <= '0;
         smp1_ff       <= 1'b0;
         smp2_ff       <= 1'b0;
         on1_ff        <= 1'b0;
         on2_ff        <= 1'b0;
         cnt1_ff       <= '0;
         cnt2_ff       <= '0;
         dff_out_ff    <= 1'b0;
         dir_out_ff    <= 1'b0;
         mode_ff       <= 1'b0;
         dir_flag_ff   <= 1'b0;
         last_state_ff <= DET_DFF_LOW;
         tick_ff       <= '0;
      end else if (accept) begin
         fb_seen_ff    <= fb_seen_in;
         in_seen_ff    <= in_seen_in;
         smp1_ff       <= smp1_in;
         smp2_ff       <= smp2_in;
         on1_ff        <= on1_in;
         on2_ff        <= on2_in;
         cnt1_ff       <= cnt1_in;
         cnt2_ff       <= cnt2_in;
         dff_out_ff    <= dff_out_in;
         dir_out_ff    <= dir_out_in;
         mode_ff       <= mode_in;
         dir_flag_ff   <= dir_flag_in;
         last_state_ff <= state_in;
         if (tick_ff != '1)
            tick_ff <= tick_ff + 1'b1;
      end
   end

   // Result valid: set on accept, drop when taken
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (accept)
         rsp_valid_ff <= 1'b1;
      else if (rsp_ch.ready)
         rsp_valid_ff <= 1'b0;
   end

   // Result payload: load on accept, hold while stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_state_ff   <= state_in;
         rsp_mode_ff    <= mode_in;
         rsp_speed_ff   <= dir_flag_in;
         rsp_dir_ff     <= dir_out_in;
         rsp_changed_ff <= changed_in;
         rsp_err_ff     <= err1 | err2;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.detector_state = rsp_state_ff;
   assign rsp_ch.source_mode    = rsp_mode_ff;
   assign rsp_ch.speed_up       = rsp_speed_ff;
   assign rsp_ch.direction_bit  = rsp_dir_ff;
   assign rsp_ch.changed        = rsp_changed_ff;
   assign rsp_ch.overlap_error  = rsp_err_ff;

endmodule : windowed_phase_detector

`default_nettype wire

[tb/wpd_checker.sv]
// Checker for the windowed phase detector: per-tick prediction and result compare.
`timescale 1ns / 1ps

module wpd_checker
   import wpd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   wpd_req_if        req_mon,
   wpd_rsp_if        rsp_mon,
   wpd_csr_if        csr_mon,
   output int        mismatch_count,
   output int        ticks_checked,
   output int        ticks_waiting
);

   localparam int FRAC_BITS    = 16;
   localparam int FRAC_ONE     = 1 << FRAC_BITS;
   localparam int FRAC_HALF    = FRAC_ONE / 2;
   localparam int FB_EDGE      = 0;   // sampler clocked by feedback crossings
   localparam int IN_EDGE      = 1;   // sampler clocked by input crossings

   typedef struct packed {
      det_state_type state;
      logic          source_mode;
      logic          speed_up;
      logic          direction_bit;
      logic          changed;
      logic          overlap_error;
   } tick_result_type;

   // Shadow copies of the configuration registers
   logic [DEADZONE_W-1:0] deadzone_reg;
   logic [WINDOW_W-1:0]   window_reg;
   logic [DELAY_W-1:0]    delay_reg;
   logic [ACQUIRE_W-1:0]  acquire_reg;

   // Detector state, one slot per sampling flip-flop
   logic [31:0]          cycles_seen [2];
   logic                 sample_bit  [2];
   logic                 timer_on    [2];
   logic [DELAY_W-1:0]   timer_count [2];
   logic                 delayed_bit [2];
   logic                 mode_flag;
   logic                 speed_flag;
   det_state_type        last_state;
   logic [TICK_W-1:0]    tick_now;

   tick_result_type expected_ticks [$];
   int mismatches = 0;
   int checked    = 0;

   // Level of the other clock at a crossing, with deadzone toggling
   function automatic logic level_at(phase_type phase, logic prev);
      int frac;
      int dz;
      frac = int'(phase[FRAC_BITS-1:0]);
      dz   = int'(deadzone_reg);
      // past a quarter cycle the deadzone folds back
      if (dz > FRAC_HALF / 2)
         dz = (dz < FRAC_HALF) ? FRAC_HALF - dz : 0;
      if (frac > dz && frac + dz < FRAC_HALF)
         return 1'b1;
      if (frac > FRAC_HALF + dz && frac + dz < FRAC_ONE)
         return 1'b0;
      return ~prev;
   endfunction

   // Take a crossing on one sampler; return 1 when its timer is still busy
   function automatic logic take_crossing(int k, phase_type own, phase_type other);
      logic overlap;
      overlap = 1'b0;
      if (own[PHASE_W-1:FRAC_BITS] >= cycles_seen[k]) begin
         if (timer_on[k]) begin
            overlap = 1'b1;
         end else begin
            sample_bit[k]  = level_at(other, sample_bit[k]);
            timer_on[k]    = 1'b1;
            timer_count[k] = delay_reg;
         end
         cycles_seen[k] = cycles_seen[k] + 32'd1;
      end
      return overlap;
   endfunction

   // Advance a delay timer that was running at the start of the tick
   function automatic void count_down(int k, logic was_on);
      if (was_on) begin
         if (timer_count[k] == '0) begin
            delayed_bit[k] = sample_bit[k];
            timer_on[k]    = 1'b0;
         end else begin
            timer_count[k] = timer_count[k] - 1'b1;
         end
      end
   endfunction

   // Advance the detector by one tick and return its result
   function automatic tick_result_type predict_tick(phase_type in_ph, phase_type fb_ph);
      logic [1:0]           was_on;
      logic                 old_mode;
      logic [FRAC_BITS-1:0] diff;
      int                   gap;
      tick_result_type      res;
      was_on   = {timer_on[IN_EDGE], timer_on[FB_EDGE]};
      old_mode = mode_flag;
      res      = '0;

      res.overlap_error = take_crossing(FB_EDGE, fb_ph, in_ph);
      count_down(FB_EDGE, was_on[FB_EDGE]);
      res.overlap_error |= take_crossing(IN_EDGE, in_ph, fb_ph);
      count_down(IN_EDGE, was_on[IN_EDGE]);

      // phase error folded into half a cycle
      diff = fb_ph[FRAC_BITS-1:0] - in_ph[FRAC_BITS-1:0];
      gap  = (int'(diff) > FRAC_HALF) ? FRAC_ONE - int'(diff) : int'(diff);

      if (gap >= int'(window_reg) && tick_now > acquire_reg) begin
         mode_flag  = 1'b1;
         speed_flag = ~delayed_bit[IN_EDGE];
         res.state  = DET_SOURCE;
      end else begin
         mode_flag  = 1'b0;
         res.state  = delayed_bit[FB_EDGE] ? DET_DFF_HIGH : DET_DFF_LOW;
      end

      res.source_mode   = mode_flag;
      res.speed_up      = speed_flag;
      res.direction_bit = delayed_bit[IN_EDGE];
      res.changed       = (res.state != last_state) || (mode_flag != old_mode);
      last_state        = res.state;
      if (tick_now != '1)
         tick_now = tick_now + 1'b1;
      return res;
   endfunction

   task automatic report_field(string name, int want, int got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Track writes, predict accepted items, compare taken results
   always @(posedge clock) begin : watch
      tick_result_type want;
      tick_result_type got;
      if (reset) begin
         deadzone_reg = '0;
         window_reg   = WINDOW_RESET;
         delay_reg    = '0;
         acquire_reg  = '0;
         for (int k = 0; k < 2; k++) begin
            cycles_seen[k] = '0;
            sample_bit[k]  = 1'b0;
            timer_on[k]    = 1'b0;
            timer_count[k] = '0;
            delayed_bit[k] = 1'b0;
         end
         mode_flag  = 1'b0;
         speed_flag = 1'b0;
         last_state = DET_DFF_LOW;
         tick_now   = '0;
         expected_ticks.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               REG_DEADZONE: deadzone_reg = csr_mon.data[DEADZONE_W-1:0];
               REG_WINDOW:   window_reg   = csr_mon.data[WINDOW_W-1:0];
               REG_DELAY:    delay_reg    = csr_mon.data[DELAY_W-1:0];
               REG_ACQUIRE:  acquire_reg  = csr_mon.data[ACQUIRE_W-1:0];
               default: ;
            endcase
         end

         if (req_mon.valid && req_mon.ready)
            expected_ticks.push_back(predict_tick(req_mon.input_phase,
                                                  req_mon.feedback_phase));

         if (rsp_mon.valid && rsp_mon.ready) begin
            got.state         = rsp_mon.detector_state;
            got.source_mode   = rsp_mon.source_mode;
            got.speed_up      = rsp_mon.speed_up;
            got.direction_bit = rsp_mon.direction_bit;
            got.changed       = rsp_mon.changed;
            got.overlap_error = rsp_mon.overlap_error;
            checked++;
            if (expected_ticks.size() == 0) begin
               mismatches++;
               $display("%0t: result item with none expected, actual state %0d",
                        $time, got.state);
            end else begin
               want = expected_ticks.pop_front();
               report_field("detector_state", want.state, got.state);
               report_field("source_mode", want.source_mode, got.source_mode);
               report_field("speed_up", want.speed_up, got.speed_up);
               report_field("direction_bit", want.direction_bit, got.direction_bit);
               report_field("changed", want.changed, got.changed);
               report_field("overlap_error", want.overlap_error, got.overlap_error);
            end
         end
      end
      mismatch_count <= mismatches;
      ticks_checked  <= checked;
      ticks_waiting  <= int'(expected_ticks.size());
   end

endmodule : wpd_checker

[tb/tb_top.sv]
// Testbench top for the windowed phase detector: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_top;
   import wpd_pkg::*;

   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_ITEMS    = 68;
   localparam int PRESSURE_PHASE = 4;
   localparam int HOLD_CYCLES    = 300;
   localparam int TAIL_CYCLES    = 8;

   logic clock;
   logic reset;

   wpd_req_if req_ch ();
   wpd_rsp_if rsp_ch ();
   wpd_csr_if csr_ch ();

   int mismatch_count;
   int ticks_checked;
   int ticks_waiting;
   int ticks_sent;
   int settings_used;
   int idle_pct;
   int stall_pct;
   int hold_left;
   int in_step;
   int fb_drift;
   logic hold_request;
   logic hold_seen;
   logic [31:0] whole;
   phase_type in_track;
   phase_type fb_track;

   windowed_phase_detector DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   wpd_checker tick_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_mon        (csr_ch),
      .mismatch_count (mismatch_count),
      .ticks_checked  (ticks_checked),
      .ticks_waiting  (ticks_waiting)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_ch.ready = 1'b0;
      hold_seen    = 1'b0;
      hold_left    = 0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_seen)
            hold_left = HOLD_CYCLES;
         hold_seen = hold_request;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   function automatic phase_type random_phase();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[PHASE_W-1:0];
   endfunction

   // Boundary fractions around zero, the quarter, the half and the wrap
   function automatic logic [15:0] edge_frac(int i);
      case (i % 9)
         0:       return 16'h0000;
         1:       return 16'h0001;
         2:       return 16'h3FFF;
         3:       return 16'h4000;
         4:       return 16'h4001;
         5:       return 16'h7FFF;
         6:       return 16'h8000;
         7:       return 16'hC000;
         default: return 16'hFFFF;
      endcase
   endfunction

   // Offer one tick, idling first at random; hold valid until taken
   task automatic send_tick(phase_type in_ph, phase_type fb_ph);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.input_phase    <= in_ph;
      req_ch.feedback_phase <= fb_ph;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      ticks_sent++;
   endtask

   task automatic write_reg(csr_index_type idx, csr_data_type value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
   endtask

   task automatic load_config(csr_data_type dz, csr_data_type win, csr_data_type dly,
                              csr_data_type acq);
      write_reg(REG_DEADZONE, dz);
      write_reg(REG_WINDOW, win);
      write_reg(REG_DELAY, dly);
      write_reg(REG_ACQUIRE, acq);
      csr_ch.valid <= 1'b0;
      settings_used++;
   endtask

   // Drop valid and hold until every tick has come back
   task automatic wait_for_results;
      req_ch.valid <= 1'b0;
      while (ticks_checked < ticks_sent) @(posedge clock);
   endtask

   // Mostly steady phase ramps; a few cycle jumps and random noise ticks
   task automatic send_next_tick;
      int pick;
      logic [31:0] jump;
      pick = $urandom_range(99);
      if (pick < 5) begin
         send_tick(random_phase(), random_phase());
      end else begin
         if (pick < 10) begin
            jump     = $urandom_range(6, 2);
            in_track = in_track + {jump, 16'h0000};
            fb_track = fb_track + {jump, 16'h0000};
         end
         in_track = in_track + phase_type'(in_step);
         fb_track = fb_track + phase_type'(in_step + fb_drift);
         send_tick(in_track, fb_track);
      end
   endtask

   initial begin
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.input_phase    = '0;
      req_ch.feedback_phase = '0;
      csr_ch.valid          = 1'b0;
      csr_ch.index          = REG_DEADZONE;
      csr_ch.data           = '0;
      hold_request          = 1'b0;
      stall_pct             = 0;
      idle_pct              = 0;
      ticks_sent            = 0;
      settings_used         = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Field extremes under the reset settings
      send_tick('0, '0);
      send_tick('1, '1);
      send_tick('1, '0);
      send_tick('0, '1);

      // Boundary fractions under folded deadzones, zero and wide windows
      whole = 32'd4;
      for (int s = 0; s < 3; s++) begin
         wait_for_results();
         case (s)
            0:       load_config(16384, 0, 0, 0);
            1:       load_config(16385, 65535, 2, 3);
            default: load_config(32767, 32'(WINDOW_RESET), 0, 32'hFFFF_FFFF);
         endcase
         for (int i = 0; i < 6; i++) begin
            send_tick({whole, edge_frac(i + s * 3)}, {whole, edge_frac(2 * i + s + 4)});
            whole++;
         end
      end

      in_track = {whole, 16'h0000};
      fb_track = {whole, 16'h2000};

      // Random ramps under a series of settings and idle mixes
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         wait_for_results();
         case (ph)
            0:       load_config(0, 16384, 0, 0);
            1:       load_config(3000, 8192, 3, 40);
            2:       load_config($urandom_range(32767), 0, 10, 0);
            3:       load_config(32767, 32'(WINDOW_RESET), 2, 0);
            4:       load_config(500, 12000, 1, 100);
            5:       load_config($urandom_range(32767), $urandom_range(36000),
                                 $urandom_range(12), $urandom_range(300));
            6:       load_config($urandom_range(32767), $urandom_range(65535),
                                 $urandom_range(12), $urandom);
            // long delay last: its timers outlive the run
            default: load_config(16384, 65535, 65535, 32'hFFFF_FFFF);
         endcase
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct <= 0;  end
            1: begin idle_pct = 76; stall_pct <= 0;  end
            2: begin idle_pct = 0;  stall_pct <= 76; end
            default: begin idle_pct = 13; stall_pct <= 13; end
         endcase
         if (ph == PRESSURE_PHASE)
            hold_request <= 1'b1;
         in_step  = $urandom_range(30000, 3000);
         fb_drift = int'($urandom_range(1400)) - 700;
         repeat (PHASE_ITEMS) send_next_tick();
         hold_request <= 1'b0;
      end

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d ticks (%0d results checked) over %0d register settings,",
               ticks_sent, ticks_checked, settings_used);
      $display("with idle and stall mixes, a long result hold-off, noise and phase jumps.");
      if (ticks_waiting != 0)
         $display("%0t: %0d expected results never arrived", $time, ticks_waiting);
      if (mismatch_count == 0 && ticks_waiting == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule : tb_top

[filelist.f]
rtl/wpd_pkg.sv
rtl/wpd_req_if.sv
rtl/wpd_rsp_if.sv
rtl/wpd_csr_if.sv
rtl/windowed_phase_detector.sv
tb/wpd_checker.sv
tb/tb_top.sv
